FILE: hw/rtl/tcw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg: shared definitions for the text console cell writer
// Field widths, character codes, op codes and the command and status
// records that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLS_DEF = 80;
    localparam int ROWS_DEF = 25;

    localparam int OP_W    = 3;
    localparam int CHAR_W  = 8;
    localparam int POS_W   = 11;
    localparam int COLOR_W = 8;
    localparam int DATA_W  = COLOR_W + CHAR_W;

    localparam logic [COLOR_W-1:0] COLOR_RESET  = 8'h01;
    localparam logic [CHAR_W-1:0]  CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0]  CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0]  CH_SPACE     = 8'd32;

    typedef enum logic [OP_W-1:0] {
        OP_PUT_CHAR   = 3'd0,
        OP_MOVE_LEFT  = 3'd1,
        OP_MOVE_RIGHT = 3'd2,
        OP_CLEAR      = 3'd3,
        OP_SAVE       = 3'd4,
        OP_RESTORE    = 3'd5,
        OP_READ_CELL  = 3'd6
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCROLL_RD,
        ST_SCROLL_WR,
        ST_FILL,
        ST_SAVE_RD,
        ST_SAVE_WR,
        ST_REST_RD,
        ST_REST_WR,
        ST_READ_WAIT,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_LEFT,
        CUR_RIGHT,
        CUR_NEXT_ROW,
        CUR_HOME,
        CUR_SAVE,
        CUR_RESTORE
    } cur_cmd_t;

    typedef enum logic [3:0] {
        MEM_NONE,
        MEM_PUT_CHAR,
        MEM_BACKSPACE,
        MEM_SCROLL_RD,
        MEM_SCROLL_WR,
        MEM_FILL,
        MEM_SAVE_RD,
        MEM_SAVE_WR,
        MEM_REST_RD,
        MEM_REST_WR,
        MEM_READ_CELL
    } mem_cmd_t;

    typedef struct packed {
        logic     load;
        cur_cmd_t cur_cmd;
        mem_cmd_t mem_cmd;
        logic     cnt_clr;
        logic     cnt_inc;
        logic     capture;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            is_newline;
        logic            is_backspace;
        logic            col_zero;
        logic            col_last;
        logic            row_last;
        logic            cnt_move_end;
        logic            cnt_end;
        logic            addr_in_range;
        logic            out_free;
    } dp_status_t;

endpackage
`default_nettype wire

FILE: hw/rtl/text_console_cell_writer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_cell_writer_unit: text console engine with scroll and snapshot
// Top level joining the controller and the datapath of the console.
// ----------------------------------------------------------------------------
// The block keeps a ROWS x COLS screen of 16-bit cells (color in the high
// byte, character in the low byte), a cursor, and a snapshot copy of the
// screen with its cursor. Every item returns one result: the linear cursor
// position after the op, and the cell read by read_cell (zero for other ops
// and for addresses beyond the screen). Items are taken one at a time. A
// read_cell on the screen passes through an extra wait state for the
// registered memory read. Scrolling copies each cell one row up with a read
// and a write state on the screen memory, then blanks the bottom row, when
// a put or newline passes the last row. Clear writes one cell a cycle; save
// and restore move each cell between the memories with a read and a write.
// The controller spends a read state and then a write state on every cell
// that it copies in scroll, save and restore; clear needs only writes. The
// screen and snapshot contents are undefined until clear or save writes
// them, so no clearing pass runs after reset. The text color register resets
// to 0x01 and is to be written only while no item is in flight; the block
// itself does not enforce this. A finished result waits in an output
// register, and the next item is taken while it waits.
// ----------------------------------------------------------------------------
module text_console_cell_writer_unit #(
    parameter int COLS = tcw_pkg::COLS_DEF,
    parameter int ROWS = tcw_pkg::ROWS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Input item channel.
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [tcw_pkg::OP_W-1:0]      op,
    input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
    input  logic [tcw_pkg::POS_W-1:0]     cell_address,
    // Result item channel.
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tcw_pkg::POS_W-1:0]     cursor_position,
    output logic [tcw_pkg::DATA_W-1:0]    cell_data,
    // Text color register write channel.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tcw_pkg::COLOR_W-1:0]   cfg_data
);
    import tcw_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       in_ready;

    // The color register can always take a write.
    assign cfg_ready = 1'b1;
    assign in_stall  = !in_ready;

    // The controller sequences each item; the datapath holds all data.
    tcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tcw_datapath #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .op              (op),
        .char_code       (char_code),
        .cell_address    (cell_address),
        .cfg_write       (cfg_valid && cfg_ready),
        .cfg_data        (cfg_data),
        .cmd             (cmd),
        .status          (status),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .cursor_position (cursor_position),
        .cell_data       (cell_data)
    );

endmodule
`default_nettype wire

FILE: hw/rtl/tcw_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ctrl: sequencer of the text console cell writer
// Decodes each item and steps the datapath through writes, scrolls,
// clears, snapshot copies and cell reads.
// ----------------------------------------------------------------------------
module tcw_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tcw_pkg::dp_status_t status,
    output tcw_pkg::dp_cmd_t   cmd
);
    import tcw_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   can_accept;

    assign can_accept = (state_reg == ST_IDLE) || ((state_reg == ST_DONE) && status.out_free);
    assign in_ready   = can_accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_DONE;
                case (status.op)
                    OP_PUT_CHAR:
                    begin
                        if (status.is_newline || (!status.is_backspace && status.col_last))
                        begin
                            if (status.row_last)
                            begin
                                state_next = ST_SCROLL_RD;
                            end
                        end
                    end
                    OP_CLEAR:     state_next = ST_FILL;
                    OP_SAVE:      state_next = ST_SAVE_RD;
                    OP_RESTORE:   state_next = ST_REST_RD;
                    OP_READ_CELL:
                    begin
                        if (status.addr_in_range)
                        begin
                            state_next = ST_READ_WAIT;
                        end
                    end
                    default:      state_next = ST_DONE;
                endcase
            end
            ST_SCROLL_RD: state_next = ST_SCROLL_WR;
            ST_SCROLL_WR: state_next = status.cnt_move_end ? ST_FILL : ST_SCROLL_RD;
            ST_FILL:      state_next = status.cnt_end ? ST_DONE : ST_FILL;
            ST_SAVE_RD:   state_next = ST_SAVE_WR;
            ST_SAVE_WR:   state_next = status.cnt_end ? ST_DONE : ST_SAVE_RD;
            ST_REST_RD:   state_next = ST_REST_WR;
            ST_REST_WR:   state_next = status.cnt_end ? ST_DONE : ST_REST_RD;
            ST_READ_WAIT: state_next = ST_DONE;
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = in_valid ? ST_DECODE : ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Datapath commands.
    always_comb
    begin
        cmd.load     = in_valid && can_accept;
        cmd.cur_cmd  = CUR_HOLD;
        cmd.mem_cmd  = MEM_NONE;
        cmd.cnt_clr  = 1'b0;
        cmd.cnt_inc  = 1'b0;
        cmd.capture  = 1'b0;
        cmd.out_load = 1'b0;
        case (state_reg)
            ST_DECODE:
            begin
                cmd.cnt_clr = 1'b1;
                case (status.op)
                    OP_PUT_CHAR:
                    begin
                        if (status.is_newline)
                        begin
                            cmd.cur_cmd = CUR_NEXT_ROW;
                        end
                        else if (status.is_backspace)
                        begin
                            if (!status.col_zero)
                            begin
                                cmd.cur_cmd = CUR_LEFT;
                                cmd.mem_cmd = MEM_BACKSPACE;
                            end
                        end
                        else
                        begin
                            cmd.mem_cmd = MEM_PUT_CHAR;
                            cmd.cur_cmd = status.col_last ? CUR_NEXT_ROW : CUR_RIGHT;
                        end
                    end
                    OP_MOVE_LEFT:  cmd.cur_cmd = CUR_LEFT;
                    OP_MOVE_RIGHT: cmd.cur_cmd = CUR_RIGHT;
                    OP_CLEAR:      cmd.cur_cmd = CUR_HOME;
                    OP_SAVE:       cmd.cur_cmd = CUR_SAVE;
                    OP_RESTORE:    cmd.cur_cmd = CUR_RESTORE;
                    OP_READ_CELL:
                    begin
                        if (status.addr_in_range)
                        begin
                            cmd.mem_cmd = MEM_READ_CELL;
                        end
                    end
                    default:       cmd.cur_cmd = CUR_HOLD;
                endcase
            end
            ST_SCROLL_RD: cmd.mem_cmd = MEM_SCROLL_RD;
            ST_SCROLL_WR:
            begin
                cmd.mem_cmd = MEM_SCROLL_WR;
                cmd.cnt_inc = 1'b1;
            end
            ST_FILL:
            begin
                cmd.mem_cmd = MEM_FILL;
                cmd.cnt_inc = !status.cnt_end;
            end
            ST_SAVE_RD:   cmd.mem_cmd = MEM_SAVE_RD;
            ST_SAVE_WR:
            begin
                cmd.mem_cmd = MEM_SAVE_WR;
                cmd.cnt_inc = !status.cnt_end;
            end
            ST_REST_RD:   cmd.mem_cmd = MEM_REST_RD;
            ST_REST_WR:
            begin
                cmd.mem_cmd = MEM_REST_WR;
                cmd.cnt_inc = !status.cnt_end;
            end
            ST_READ_WAIT: cmd.capture = 1'b1;
            ST_DONE:      cmd.out_load = status.out_free;
            default:      cmd.load = in_valid && can_accept;
        endcase
    end

    // An accepted item is always decoded in the following cycle.
    a_load_decodes: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_DECODE))
        else $error("accepted item was not decoded");

    // The memories stay untouched while no item is in progress.
    a_idle_no_mem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (cmd.mem_cmd == MEM_NONE))
        else $error("memory command issued while idle");

endmodule
`default_nettype wire

FILE: hw/rtl/tcw_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_datapath: cursor, screen and snapshot memories of the console
// Holds the cursor and saved cursor, the two cell memories, the sweep
// counter and the result register, driven by controller commands.
// ----------------------------------------------------------------------------
module tcw_datapath #(
    parameter int COLS = tcw_pkg::COLS_DEF,
    parameter int ROWS = tcw_pkg::ROWS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tcw_pkg::OP_W-1:0]      op,
    input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
    input  logic [tcw_pkg::POS_W-1:0]     cell_address,
    input  logic                          cfg_write,
    input  logic [tcw_pkg::COLOR_W-1:0]   cfg_data,
    input  tcw_pkg::dp_cmd_t              cmd,
    output tcw_pkg::dp_status_t           status,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic [tcw_pkg::POS_W-1:0]     cursor_position,
    output logic [tcw_pkg::DATA_W-1:0]    cell_data
);
    import tcw_pkg::*;

    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLS);
    localparam int EXT_W  = ADDR_W + POS_W;
    localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(COLS);
    localparam logic [ADDR_W-1:0] MOVE_END_A = ADDR_W'(CELLS - COLS - 1);
    localparam logic [ADDR_W-1:0] CELL_END_A = ADDR_W'(CELLS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLS - 1);

    logic [DATA_W-1:0] screen_mem   [CELLS];
    logic [DATA_W-1:0] snapshot_mem [CELLS];

    logic [OP_W-1:0]    op_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic [POS_W-1:0]   addr_reg;
    logic [COLOR_W-1:0] color_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   saved_row_reg;
    logic [COL_W-1:0]   saved_col_reg;
    logic [ADDR_W-1:0]  cnt_reg;
    logic [DATA_W-1:0]  data_reg;
    logic [DATA_W-1:0]  scr_rdata_reg;
    logic [DATA_W-1:0]  snp_rdata_reg;
    logic               out_valid_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [DATA_W-1:0]  out_data_reg;

    logic [ADDR_W-1:0]  cur_lin;
    logic [EXT_W-1:0]   cur_lin_ext;
    logic [EXT_W-1:0]   addr_ext;
    logic [DATA_W-1:0]  space_word;
    logic               scr_re;
    logic [ADDR_W-1:0]  scr_raddr;
    logic               scr_we;
    logic [ADDR_W-1:0]  scr_waddr;
    logic [DATA_W-1:0]  scr_wdata;
    logic               snp_re;
    logic               snp_we;

    assign cur_lin     = ADDR_W'(row_reg) * COLS_A + ADDR_W'(col_reg);
    assign cur_lin_ext = EXT_W'(cur_lin);
    assign addr_ext    = EXT_W'(addr_reg);
    assign space_word  = {color_reg, CH_SPACE};

    assign status.op            = op_reg;
    assign status.is_newline    = (char_reg == CH_NEWLINE);
    assign status.is_backspace  = (char_reg == CH_BACKSPACE);
    assign status.col_zero      = (col_reg == '0);
    assign status.col_last      = (col_reg == COL_LAST);
    assign status.row_last      = (row_reg == ROW_LAST);
    assign status.cnt_move_end  = (cnt_reg == MOVE_END_A);
    assign status.cnt_end       = (cnt_reg == CELL_END_A);
    assign status.addr_in_range = (addr_ext < EXT_W'(CELLS));
    assign status.out_free      = !out_valid_reg || !out_stall;

    // Memory port selection.
    always_comb
    begin
        scr_re    = 1'b0;
        scr_raddr = cnt_reg;
        scr_we    = 1'b0;
        scr_waddr = cnt_reg;
        scr_wdata = space_word;
        snp_re    = 1'b0;
        snp_we    = 1'b0;
        case (cmd.mem_cmd)
            MEM_PUT_CHAR:
            begin
                scr_we    = 1'b1;
                scr_waddr = cur_lin;
                scr_wdata = {color_reg, char_reg};
            end
            MEM_BACKSPACE:
            begin
                scr_we    = 1'b1;
                scr_waddr = cur_lin - ADDR_W'(1);
            end
            MEM_SCROLL_RD:
            begin
                scr_re    = 1'b1;
                scr_raddr = cnt_reg + COLS_A;
            end
            MEM_SCROLL_WR:
            begin
                scr_we    = 1'b1;
                scr_wdata = scr_rdata_reg;
            end
            MEM_FILL:      scr_we = 1'b1;
            MEM_SAVE_RD:   scr_re = 1'b1;
            MEM_SAVE_WR:   snp_we = 1'b1;
            MEM_REST_RD:   snp_re = 1'b1;
            MEM_REST_WR:
            begin
                scr_we    = 1'b1;
                scr_wdata = snp_rdata_reg;
            end
            MEM_READ_CELL:
            begin
                scr_re    = 1'b1;
                scr_raddr = addr_ext[ADDR_W-1:0];
            end
            default:       scr_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (scr_we)
        begin
            screen_mem[scr_waddr] <= scr_wdata;
        end
        if (scr_re)
        begin
            scr_rdata_reg <= screen_mem[scr_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (snp_we)
        begin
            snapshot_mem[cnt_reg] <= scr_rdata_reg;
        end
        if (snp_re)
        begin
            snp_rdata_reg <= snapshot_mem[cnt_reg];
        end
    end

    // Item fields and the read result; payload only.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op;
            char_reg <= char_code;
            addr_reg <= cell_address;
            data_reg <= '0;
        end
        else if (cmd.capture)
        begin
            data_reg <= scr_rdata_reg;
        end
        if (cmd.out_load)
        begin
            pos_reg      <= cur_lin_ext[POS_W-1:0];
            out_data_reg <= data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg     <= COLOR_RESET;
            row_reg       <= '0;
            col_reg       <= '0;
            saved_row_reg <= '0;
            saved_col_reg <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                color_reg <= cfg_data;
            end
            case (cmd.cur_cmd)
                CUR_LEFT:
                begin
                    if (col_reg != '0)
                    begin
                        col_reg <= col_reg - COL_W'(1);
                    end
                end
                CUR_RIGHT:
                begin
                    if (col_reg != COL_LAST)
                    begin
                        col_reg <= col_reg + COL_W'(1);
                    end
                end
                CUR_NEXT_ROW:
                begin
                    col_reg <= '0;
                    if (row_reg != ROW_LAST)
                    begin
                        row_reg <= row_reg + ROW_W'(1);
                    end
                end
                CUR_HOME:
                begin
                    row_reg <= '0;
                    col_reg <= '0;
                end
                CUR_SAVE:
                begin
                    saved_row_reg <= row_reg;
                    saved_col_reg <= col_reg;
                end
                CUR_RESTORE:
                begin
                    row_reg <= saved_row_reg;
                    col_reg <= saved_col_reg;
                end
                default:
                begin
                    row_reg <= row_reg;
                end
            endcase
            if (cmd.cnt_clr)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + ADDR_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign cursor_position = pos_reg;
    assign cell_data       = out_data_reg;

    // The cursor never leaves the screen.
    a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg < ROWS) && (col_reg < COLS))
        else $error("cursor outside the screen");

    // A waiting result is never overwritten.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !cmd.out_load)
        else $error("pending result overwritten");

endmodule
`default_nettype wire
